### sv/frmar_pkg.sv
// ============================================================================
// frmar_pkg
// Shared widths, register indexes and saturation helpers for the flex row
// main-axis resolver.
// ============================================================================
`default_nettype none

package frmar_pkg;

    localparam int MAX_ITEMS_DEF = 64;

    localparam int LEN_W     = 32;             // Q23.8 lengths
    localparam int PAD_W     = 31;             // unsigned paddings and borders
    localparam int GROW_W    = 16;             // Q8.8 grow factor
    localparam int GTOT_W    = 23;             // grow sum
    localparam int TOTAL_W   = 40;             // saturating basis sum
    localparam int SLACK_W   = 42;             // signed free space
    localparam int FREEP_W   = 40;             // positive free space bits
    localparam int HALF_W    = FREEP_W / 2;    // free space split for multiply
    localparam int PROD_W    = GROW_W + FREEP_W;
    localparam int DIV_STEPS = PROD_W / 2;     // two quotient bits per cycle
    localparam int ENTRY_W   = GROW_W + LEN_W; // one row entry in memory

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_AVAIL_WIDTH = 3'd0,
        REG_PAD_LEFT    = 3'd1,
        REG_PAD_RIGHT   = 3'd2,
        REG_EDGE_LEFT   = 3'd3,
        REG_EDGE_RIGHT  = 3'd4,
        REG_ORIGIN_X    = 3'd5,
        REG_START_Y     = 3'd6,
        REG_SPARE_ZERO  = 3'd7
    } t_reg_idx;

    localparam int BASIS_KIND_LENGTH = 1;

    // Clamp a signed value to the 32-bit signed range.
    function automatic logic signed [LEN_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [LEN_W-1:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[LEN_W-1:0];
        end
        return res;
    endfunction

    // Clamp a signed value to the 40-bit signed range of the basis sum.
    function automatic logic signed [TOTAL_W-1:0] sat40(input logic signed [63:0] v);
        logic signed [TOTAL_W-1:0] res;
        if (v > 64'sd549755813887) begin
            res = {1'b0, {(TOTAL_W-1){1'b1}}};
        end else if (v < -64'sd549755813888) begin
            res = {1'b1, {(TOTAL_W-1){1'b0}}};
        end else begin
            res = v[TOTAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/frmar_divider.sv
// ============================================================================
// frmar_divider
// Unsigned restoring divider that retires two quotient bits per cycle.
// ============================================================================
`default_nettype none

module frmar_divider (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [frmar_pkg::PROD_W-1:0]      i_dividend,
    input  wire [frmar_pkg::GTOT_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [frmar_pkg::PROD_W-1:0]     o_quotient
);
    import frmar_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_num;
    logic [GTOT_W-1:0]   r_rem;
    logic [GTOT_W-1:0]   r_div;

    logic [GTOT_W:0]     s1;
    logic [GTOT_W:0]     s2;
    logic                ge1;
    logic                ge2;
    logic [GTOT_W-1:0]   rem1;
    logic [GTOT_W-1:0]   n_rem;

    // The partial remainder stays below the divisor, so it fits in GTOT_W bits.
    always_comb begin
        s1    = {r_rem, r_num[PROD_W-1]};
        ge1   = s1 >= {1'b0, r_div};
        rem1  = ge1 ? GTOT_W'(s1 - {1'b0, r_div}) : s1[GTOT_W-1:0];
        s2    = {rem1, r_num[PROD_W-2]};
        ge2   = s2 >= {1'b0, r_div};
        n_rem = ge2 ? GTOT_W'(s2 - {1'b0, r_div}) : s2[GTOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[PROD_W-3:0], ge1, ge2};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_num;

endmodule

`default_nettype wire

### sv/flex_row_main_axis_resolver_unit.sv
// ============================================================================
// flex_row_main_axis_resolver_unit
// Loads one flex row item per transaction and places the whole row, growing
// items into the free space, once the item marked last has been taken.
// ============================================================================
// A row is loaded one item per input transaction, one item a cycle, while the
// block is idle. Each item's basis and grow factor go into a row memory, and
// the running basis sum, grow sum and tallest height are kept in registers.
// The transaction that carries the last mark closes the row: the block then
// stops taking input, works out the free space in the S_FREE_A and S_FREE_B
// states, and places the stored items one after another. An item that grows
// passes through the memory read, a split 16x40 multiply, the partial product
// sum, a divider that retires two quotient bits per cycle, and the width add
// with the output load; an item that does not grow skips the divider. A
// result sits in an output register until it is taken, and a stalled output
// holds the placement of the next item. After the final result has been
// loaded the block is idle again and takes the first item of the next row
// while that result may still be waiting. Items beyond MAX_ITEMS in one row
// are dropped, though a last mark on such an item still closes the row. The
// user must write the configuration registers through the APB port only
// while the block is idle; the block itself does not enforce it.
// ============================================================================
`default_nettype none

module flex_row_main_axis_resolver_unit #(
    parameter int MAX_ITEMS = frmar_pkg::MAX_ITEMS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,

    // APB configuration port
    input  wire                                    psel,
    input  wire                                    penable,
    input  wire                                    pwrite,
    input  wire  [frmar_pkg::PADDR_W-1:0]          paddr,
    input  wire  [frmar_pkg::PDATA_W-1:0]          pwdata,
    output logic [frmar_pkg::PDATA_W-1:0]          prdata,
    output logic                                   pready,

    // Item input channel
    input  wire                                    i_valid,
    output logic                                   o_ready,
    input  wire                                    i_grow_is_number,
    input  wire  [frmar_pkg::GROW_W-1:0]           i_grow_factor,
    input  wire  [1:0]                             i_basis_kind,
    input  wire  signed [frmar_pkg::LEN_W-1:0]     i_basis_length,
    input  wire  signed [frmar_pkg::LEN_W-1:0]     i_item_content_width,
    input  wire  signed [frmar_pkg::LEN_W-1:0]     i_item_content_height,
    input  wire                                    i_last_item,

    // Result output channel
    output logic                                   o_valid,
    input  wire                                    i_ready,
    output logic signed [frmar_pkg::LEN_W-1:0]     o_item_x,
    output logic signed [frmar_pkg::LEN_W-1:0]     o_item_y,
    output logic signed [frmar_pkg::LEN_W-1:0]     o_main_size,
    output logic signed [frmar_pkg::LEN_W-1:0]     o_row_height,
    output logic                                   o_last_result
);
    import frmar_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FREE_A = 8'b0000_0010,
        S_FREE_B = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_PROD   = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    // Configuration registers
    logic signed [LEN_W-1:0]   r_avail;
    logic [PAD_W-1:0]          r_pad_l;
    logic [PAD_W-1:0]          r_pad_r;
    logic [PAD_W-1:0]          r_edge_l;
    logic [PAD_W-1:0]          r_edge_r;
    logic signed [LEN_W-1:0]   r_origin_x;
    logic signed [LEN_W-1:0]   r_start_y;

    // Row state
    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_k;
    logic signed [TOTAL_W-1:0] r_total;
    logic [GTOT_W-1:0]         r_gtot;
    logic signed [LEN_W-1:0]   r_tallest;

    // Row memory: grow factor above basis
    logic [ENTRY_W-1:0]        mem [MAX_ITEMS];
    logic [ENTRY_W-1:0]        r_rd;

    // Placement datapath
    logic signed [SLACK_W-1:0] r_free_a;
    logic [PAD_W+1:0]          r_pads;
    logic signed [SLACK_W-1:0] r_free;
    logic signed [LEN_W-1:0]   r_x;
    logic signed [LEN_W-1:0]   r_basis;
    logic                      r_grow;
    logic [GROW_W+HALF_W-1:0]  r_pl;
    logic [GROW_W+HALF_W-1:0]  r_ph;

    // Output register
    logic                      r_ovalid;
    logic signed [LEN_W-1:0]   r_o_x;
    logic signed [LEN_W-1:0]   r_o_y;
    logic signed [LEN_W-1:0]   r_o_w;
    logic signed [LEN_W-1:0]   r_o_h;
    logic                      r_o_last;

    // Next values
    logic                      in_take;
    logic                      room;
    logic                      cfg_wr;
    t_reg_idx                  cfg_idx;
    logic signed [LEN_W-1:0]   n_basis;
    logic [GROW_W-1:0]         n_grow;
    logic signed [TOTAL_W-1:0] n_total;
    logic [GTOT_W-1:0]         n_gtot;
    logic [GROW_W-1:0]         rd_grow;
    logic signed [LEN_W-1:0]   rd_basis;
    logic                      free_pos;
    logic                      row_done;
    logic                      out_free;
    logic                      div_start;
    logic                      div_done;
    logic [PROD_W-1:0]         div_quo;
    logic [PROD_W-1:0]         n_prod;
    logic [PROD_W-1:0]         quo;
    logic signed [LEN_W-1:0]   n_w;

    assign in_take = i_valid && o_ready;
    assign room    = r_count < CNT_W'(MAX_ITEMS);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    // Basis selection, and the saturating sums for one loaded item.
    always_comb begin
        n_basis = (i_basis_kind == 2'(BASIS_KIND_LENGTH)) ? i_basis_length
                                                          : i_item_content_width;
        if (n_basis == '0) begin
            n_basis = i_item_content_width;
        end
        n_grow  = i_grow_is_number ? i_grow_factor : '0;
        n_total = sat40(64'(r_total) + 64'(n_basis));
        n_gtot  = r_gtot + GTOT_W'(n_grow);
    end

    assign rd_grow  = r_rd[ENTRY_W-1:LEN_W];
    assign rd_basis = r_rd[LEN_W-1:0];
    assign free_pos = !r_free[SLACK_W-1] && (r_free != '0);
    assign row_done = (r_k + 1'b1) == r_count;
    assign out_free = !r_ovalid || i_ready;

    // The two partial products meet here; the free space is below 2^40 when
    // positive, so the full product fits in PROD_W bits.
    assign n_prod    = {r_ph, HALF_W'(0)} + PROD_W'(r_pl);
    assign div_start = (r_state == S_PROD) && r_grow;
    assign quo       = r_grow ? div_quo : '0;
    assign n_w       = sat32(64'(r_basis) + 64'(quo));

    frmar_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_prod),
        .i_divisor  (r_gtot),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take && i_last_item) begin
                    n_state = S_FREE_A;
                end
            end
            S_FREE_A: n_state = S_FREE_B;
            S_FREE_B: n_state = S_READ;
            S_READ:   n_state = S_MUL;
            S_MUL:    n_state = S_PROD;
            S_PROD: begin
                // Items that do not grow skip the divider and keep their basis.
                n_state = r_grow ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = row_done ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail    <= '0;
            r_pad_l    <= '0;
            r_pad_r    <= '0;
            r_edge_l   <= '0;
            r_edge_r   <= '0;
            r_origin_x <= '0;
            r_start_y  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_AVAIL_WIDTH: r_avail    <= pwdata;
                REG_PAD_LEFT:    r_pad_l    <= pwdata[PAD_W-1:0];
                REG_PAD_RIGHT:   r_pad_r    <= pwdata[PAD_W-1:0];
                REG_EDGE_LEFT:   r_edge_l   <= pwdata[PAD_W-1:0];
                REG_EDGE_RIGHT:  r_edge_r   <= pwdata[PAD_W-1:0];
                REG_ORIGIN_X:    r_origin_x <= pwdata;
                REG_START_Y:     r_start_y  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_AVAIL_WIDTH: prdata = r_avail;
            REG_PAD_LEFT:    prdata = {1'b0, r_pad_l};
            REG_PAD_RIGHT:   prdata = {1'b0, r_pad_r};
            REG_EDGE_LEFT:   prdata = {1'b0, r_edge_l};
            REG_EDGE_RIGHT:  prdata = {1'b0, r_edge_r};
            REG_ORIGIN_X:    prdata = r_origin_x;
            REG_START_Y:     prdata = r_start_y;
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Control state: sequencer, row counters and running sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_k       <= '0;
            r_total   <= '0;
            r_gtot    <= '0;
            r_tallest <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // A new result replaces the one leaving in the same cycle.
            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take && room) begin
                        r_count <= r_count + 1'b1;
                        r_total <= n_total;
                        r_gtot  <= n_gtot;
                        if (i_item_content_height > r_tallest) begin
                            r_tallest <= i_item_content_height;
                        end
                    end
                end
                S_FREE_A: r_k <= '0;
                S_EMIT: begin
                    if (out_free) begin
                        r_k <= r_k + 1'b1;
                        if (row_done) begin
                            r_count   <= '0;
                            r_total   <= '0;
                            r_gtot    <= '0;
                            r_tallest <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Row memory: written while loading, read through a register for the item being placed.
    always_ff @(posedge i_clk) begin
        if (in_take && room) begin
            mem[r_count[AW-1:0]] <= {n_grow, n_basis};
        end
        r_rd <= mem[r_k[AW-1:0]];
    end

    // Placement datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_FREE_A: begin
                r_free_a <= SLACK_W'(r_avail) - SLACK_W'(r_total);
                r_pads   <= (PAD_W+2)'(r_pad_l) + (PAD_W+2)'(r_pad_r)
                          + (PAD_W+2)'(r_edge_l) + (PAD_W+2)'(r_edge_r);
                r_x      <= sat32(64'(r_origin_x) + 64'(r_pad_l) + 64'(r_edge_l));
            end
            S_FREE_B: begin
                r_free <= r_free_a - SLACK_W'(r_pads);
            end
            S_MUL: begin
                r_basis <= rd_basis;
                r_grow  <= free_pos && (r_gtot != '0) && (rd_grow != '0);
                r_pl    <= rd_grow * r_free[HALF_W-1:0];
                r_ph    <= rd_grow * r_free[FREEP_W-1:HALF_W];
            end
            S_EMIT: begin
                if (out_free) begin
                    r_x <= sat32(64'(r_x) + 64'(n_w));
                end
            end
            default: ;
        endcase
    end

    // Output register, loaded when the previous result is gone or leaving.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_o_x    <= r_x;
            r_o_y    <= r_start_y;
            r_o_w    <= n_w;
            r_o_h    <= r_tallest;
            r_o_last <= row_done;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_item_x      = r_o_x;
    assign o_item_y      = r_o_y;
    assign o_main_size   = r_o_w;
    assign o_row_height  = r_o_h;
    assign o_last_result = r_o_last;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flex row resolver testbench
// Loads rows of flex items through the item channel and checks every placed
// item against a scoreboard that predicts basis, growth and placement.
// ----------------------------------------------------------------------------
module testbench;

    // Q23.8 lengths: one pixel is 256 counts.
    localparam int PX = 256;
    localparam int MAX_ROW = frmar_pkg::MAX_ITEMS_DEF;

    // Basis kinds as the item channel encodes them.
    localparam bit [1:0] KIND_AUTO    = 2'd0;
    localparam bit [1:0] KIND_LENGTH  = 2'(frmar_pkg::BASIS_KIND_LENGTH);
    localparam bit [1:0] KIND_OTHER   = 2'd2;
    localparam bit [1:0] KIND_UNKNOWN = 2'd3;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S40_MAX = 64'sd549755813887;
    localparam longint S40_MIN = -64'sd549755813888;

    // Cycles allowed after the last expected placement before the block is
    // considered idle, for configuration writes and at the end of the run.
    localparam int DRAIN_CYCLES = 40;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES = 400;
    // Hard stop for a hung run.
    localparam longint TIMEOUT_NS = 10_000_000;

    typedef struct {
        bit               gin;
        bit        [15:0] gf;
        bit        [1:0]  kind;
        bit signed [31:0] blen;
        bit signed [31:0] cw;
        bit signed [31:0] ch;
        bit               last;
    } item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] w;
        logic signed [31:0] h;
        logic               last;
    } place_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the container registers and of the
    // row being loaded, and turns each closed row into expected placements.
    // ------------------------------------------------------------------------
    class row_scoreboard;
        longint avail, pad_l, pad_r, edge_l, edge_r, org_x, top_y;
        bit signed [31:0] basis_mem [MAX_ROW];
        bit        [15:0] grow_mem [MAX_ROW];
        int unsigned      held;
        longint           basis_sum;
        bit        [22:0] grow_sum;
        longint           tallest;
        place_t           placements [$];
        int               failures;

        static function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(frmar_pkg::t_reg_idx idx, bit [31:0] v);
            case (idx)
                frmar_pkg::REG_AVAIL_WIDTH: avail  = longint'(signed'(v));
                frmar_pkg::REG_PAD_LEFT:    pad_l  = longint'(v[30:0]);
                frmar_pkg::REG_PAD_RIGHT:   pad_r  = longint'(v[30:0]);
                frmar_pkg::REG_EDGE_LEFT:   edge_l = longint'(v[30:0]);
                frmar_pkg::REG_EDGE_RIGHT:  edge_r = longint'(v[30:0]);
                frmar_pkg::REG_ORIGIN_X:    org_x  = longint'(signed'(v));
                frmar_pkg::REG_START_Y:     top_y  = longint'(signed'(v));
                default: ;
            endcase
        endfunction

        function void note_item(item_t it);
            longint    basis;
            bit [15:0] g;
            longint    free_space;
            longint    x;
            longint    w;
            place_t    p;
            // Items past a full row are dropped, but their last mark still
            // closes the row.
            if (held < MAX_ROW) begin
                basis = (it.kind == KIND_LENGTH) ? longint'(it.blen) : longint'(it.cw);
                if (basis == 0) basis = longint'(it.cw);
                g = it.gin ? it.gf : 16'd0;
                basis_mem[held] = basis[31:0];
                grow_mem[held] = g;
                held++;
                basis_sum = clamp(basis_sum + basis, S40_MIN, S40_MAX);
                grow_sum = grow_sum + 23'(g);
                if (longint'(it.ch) > tallest) tallest = longint'(it.ch);
            end
            if (!it.last) return;
            free_space = avail - basis_sum - pad_l - pad_r - edge_l - edge_r;
            x = clamp(org_x + pad_l + edge_l, S32_MIN, S32_MAX);
            for (int k = 0; k < held; k++) begin
                w = longint'(basis_mem[k]);
                if (free_space > 0 && grow_sum != 0 && grow_mem[k] != 0) begin
                    w = clamp(w + (longint'(grow_mem[k]) * free_space) / longint'(grow_sum),
                              S32_MIN, S32_MAX);
                end
                p.x = x[31:0];
                p.y = top_y[31:0];
                p.w = w[31:0];
                p.h = tallest[31:0];
                p.last = (k == held - 1);
                placements.insert(placements.size(), p);
                x = clamp(x + w, S32_MIN, S32_MAX);
            end
            held = 0;
            basis_sum = 0;
            grow_sum = '0;
            tallest = 0;
        endfunction

        function void match(string name, logic signed [31:0] want, logic signed [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] w, logic signed [31:0] h,
                                   logic last);
            place_t want;
            if (placements.size() == 0) begin
                $error("placement with nothing expected: x %0d width %0d", x, w);
                failures++;
                return;
            end
            want = placements.pop_front();
            match("item_x", want.x, x);
            match("item_y", want.y, y);
            match("main_size", want.w, w);
            match("row_height", want.h, h);
            match("last_result", {31'd0, want.last}, {31'd0, last});
        endfunction

        function int pending();
            return placements.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_grow_is_number = 1'b0;
    logic [15:0]        i_grow_factor = '0;
    logic [1:0]         i_basis_kind = '0;
    logic signed [31:0] i_basis_length = '0;
    logic signed [31:0] i_item_content_width = '0;
    logic signed [31:0] i_item_content_height = '0;
    logic               i_last_item = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_item_x;
    logic signed [31:0] o_item_y;
    logic signed [31:0] o_main_size;
    logic signed [31:0] o_row_height;
    logic               o_last_result;

    row_scoreboard sb = new;

    // Idle percentages for the two sides, changed per phase by the stimulus.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // A long receiver hold-off is requested by bumping hold_req; the receiver
    // process notices the change and counts the stall out on its own.
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    flex_row_main_axis_resolver_unit i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_grow_is_number      (i_grow_is_number),
        .i_grow_factor         (i_grow_factor),
        .i_basis_kind          (i_basis_kind),
        .i_basis_length        (i_basis_length),
        .i_item_content_width  (i_item_content_width),
        .i_item_content_height (i_item_content_height),
        .i_last_item           (i_last_item),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_item_x              (o_item_x),
        .o_item_y              (o_item_y),
        .o_main_size           (o_main_size),
        .o_row_height          (o_row_height),
        .o_last_result         (o_last_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard limit on the run time in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side. The values read right after the edge are the ones the
    // block saw at that edge, so a transaction is checked when o_valid and
    // i_ready were both high, and the next i_ready is then scheduled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_item_x, o_item_y, o_main_size, o_row_height, o_last_result);
        end
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All of them are entered right after a rising edge and return
    // right after one.
    // ------------------------------------------------------------------------

    // One APB write. The setup phase of the next write may follow straight
    // after the access phase, so psel is only dropped by the caller.
    task automatic apb_write(input frmar_pkg::t_reg_idx idx, input bit [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, v);
    endtask

    // Writes every container register; the reserved one gets a random bit.
    task automatic apply_setting(input bit [31:0] avail, input bit [31:0] pl,
                                 input bit [31:0] pr, input bit [31:0] el,
                                 input bit [31:0] er, input bit [31:0] ox,
                                 input bit [31:0] sy);
        apb_write(frmar_pkg::REG_AVAIL_WIDTH, avail);
        apb_write(frmar_pkg::REG_PAD_LEFT, pl);
        apb_write(frmar_pkg::REG_PAD_RIGHT, pr);
        apb_write(frmar_pkg::REG_EDGE_LEFT, el);
        apb_write(frmar_pkg::REG_EDGE_RIGHT, er);
        apb_write(frmar_pkg::REG_ORIGIN_X, ox);
        apb_write(frmar_pkg::REG_START_Y, sy);
        apb_write(frmar_pkg::REG_SPARE_ZERO, {31'd0, 1'($urandom)});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // A setting that leaves room to grow for rows of ordinary items.
    task automatic apply_typical_setting();
        apply_setting(32'($urandom_range(500, 3000) * PX), 32'($urandom_range(0, 20) * PX),
                      32'($urandom_range(0, 20) * PX), 32'($urandom_range(0, 4) * PX),
                      32'($urandom_range(0, 4) * PX),
                      32'(signed'($urandom_range(0, 4000) * PX) - 2000 * PX),
                      32'(signed'($urandom_range(0, 4000) * PX) - 2000 * PX));
    endtask

    // Offers one item, idling first at the sender's rate, and holds it until
    // the block takes it.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_grow_is_number <= it.gin;
        i_grow_factor <= it.gf;
        i_basis_kind <= it.kind;
        i_basis_length <= it.blen;
        i_item_content_width <= it.cw;
        i_item_content_height <= it.ch;
        i_last_item <= it.last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(it);
    endtask

    // Stops offering items and waits until every placement has come back,
    // plus a margin so that the block is surely idle.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic item_t make_item(input bit gin, input bit [15:0] gf, input bit [1:0] kind,
                                        input bit [31:0] blen, input bit [31:0] cw,
                                        input bit [31:0] ch, input bit last);
        item_t it;
        it.gin = gin;
        it.gf = gf;
        it.kind = kind;
        it.blen = blen;
        it.cw = cw;
        it.ch = ch;
        it.last = last;
        return it;
    endfunction

    // Most items look like real layout input, so rows actually grow; about
    // one in five is raw noise over the full range of every field.
    function automatic item_t random_item(input bit last);
        item_t it;
        if ($urandom_range(99) < 20) begin
            it.gin = 1'($urandom);
            it.gf = 16'($urandom);
            it.kind = 2'($urandom);
            it.blen = $urandom;
            it.cw = $urandom;
            it.ch = $urandom;
        end else begin
            it.gin = ($urandom_range(99) < 85);
            it.gf = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 1024));
            case ($urandom_range(9))
                0: it.kind = KIND_AUTO;
                1: it.kind = KIND_OTHER;
                2: it.kind = KIND_UNKNOWN;
                default: it.kind = KIND_LENGTH;
            endcase
            it.blen = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(0, 200 * PX));
            it.cw = 32'($urandom_range(0, 200 * PX));
            it.ch = 32'(signed'($urandom_range(0, 310 * PX)) - 10 * PX);
        end
        it.last = last;
        return it;
    endfunction

    task automatic send_row(input int len);
        for (int k = 0; k < len; k++) send_item(random_item(k == len - 1));
    endtask

    // Rows of random length, mostly short, now and then a long one that may overflow.
    task automatic random_rows(input int target);
        int sent;
        int len;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(99) < 3) len = int'($urandom_range(62, 70));
            else len = int'($urandom_range(1, 10));
            send_row(len);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus. Each phase ends on a closed row and is drained before the
    // container registers are rewritten.
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0: directed rows under a plain container. The sender idles
        // in about a third of the cycles and the receiver in most of them.
        send_idle_pct = 32;
        recv_idle_pct = 82;
        apply_setting(32'(800 * PX), 32'(4 * PX), 32'(6 * PX), 32'(PX), 32'(PX),
                      32'(10 * PX), 32'(20 * PX));
        // A single item that takes all the free space.
        send_item(make_item(1, 16'h0100, KIND_LENGTH, 100 * PX, 50 * PX, 50 * PX, 1));
        // Every basis kind: auto, length of zero falling back to content,
        // other, unknown, and a number-less grow with a nonzero factor.
        send_item(make_item(1, 16'h0100, KIND_AUTO, 0, 80 * PX, -5 * PX, 0));
        send_item(make_item(1, 16'hffff, KIND_LENGTH, 0, 60 * PX, 30 * PX, 0));
        send_item(make_item(1, 16'h0000, KIND_OTHER, 7 * PX, 40 * PX, 10 * PX, 0));
        send_item(make_item(0, 16'h0200, KIND_UNKNOWN, 999 * PX, 30 * PX, 20 * PX, 0));
        send_item(make_item(1, 16'h0080, KIND_LENGTH, 20 * PX, 5 * PX, 15 * PX, 1));
        // Field extremes; the bases cancel, so the row still grows.
        send_item(make_item(1, 16'h0001, KIND_LENGTH, 32'h7fffffff, 0, 32'h7fffffff, 0));
        send_item(make_item(1, 16'hffff, KIND_LENGTH, 32'h80000000, 10 * PX, 32'h80000000, 0));
        send_item(make_item(1, 16'h0100, KIND_AUTO, 0, 32'h7fffffff, 0, 0));
        send_item(make_item(1, 16'h0100, KIND_OTHER, 0, 32'h80000000, -1, 1));
        // No grow at all: every width stays at its basis.
        send_item(make_item(0, 16'hffff, KIND_LENGTH, 50 * PX, 0, 0, 0));
        send_item(make_item(1, 16'h0000, KIND_AUTO, 0, 70 * PX, 0, 1));
        // Bases wider than the container: negative free space.
        send_item(make_item(1, 16'h0100, KIND_LENGTH, 900 * PX, 0, 40 * PX, 0));
        send_item(make_item(1, 16'h0100, KIND_LENGTH, 30 * PX, 0, 0, 1));
        // Zero basis with zero content and only negative heights.
        send_item(make_item(0, 16'h0000, KIND_LENGTH, 0, 0, -3 * PX, 1));
        // Unknown kind ignoring a huge length, then a negative basis.
        send_item(make_item(1, 16'h0300, KIND_UNKNOWN, 32'h7fffffff, 25 * PX, 12 * PX, 0));
        send_item(make_item(1, 16'h0100, KIND_LENGTH, -40 * PX, 0, 8 * PX, 1));
        drain();

        // Phase 1: every register gets raw random bits.
        apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_rows(70);
        drain();

        // Phase 2: idle rates swap. The receiver first stalls for a long
        // stretch while rows keep coming, so the block backs up and holds its
        // input. Then a row that overflows, closed by a dropped item.
        send_idle_pct = 82;
        recv_idle_pct = 32;
        apply_typical_setting();
        hold_req++;
        random_rows(30);
        send_row(70);
        random_rows(40);
        drain();

        // Phase 3: the widest container with no edges, x pinned at the top
        // of its range and y at the bottom.
        apply_setting(32'h7fffffff, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7fffffff, 32'h80000000);
        random_rows(70);
        drain();

        // Phase 4: no idling on either side. Narrowest container, widest
        // paddings and borders (bit 31 of those must be ignored).
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(32'h80000000, 32'hffffffff, 32'h7fffffff, 32'hffffffff, 32'h7fffffff,
                      32'h80000000, 32'h7fffffff);
        random_rows(70);
        drain();

        // Phase 5: a typical container again, with a row that fills the row
        // memory exactly.
        apply_typical_setting();
        send_row(MAX_ROW);
        random_rows(30);
        drain();

        if (sb.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
sv/frmar_pkg.sv
sv/frmar_divider.sv
sv/flex_row_main_axis_resolver_unit.sv
tb/sv/testbench.sv
